// File: rtl/core/r1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package r1md_pkg;

	// payload widths
	localparam int TAG_W   = 6;
	localparam int KIND_W  = 3;
	localparam int OFF_W   = 48;
	localparam int BLK_W   = 32;
	localparam int ACC_W   = 4;
	localparam int CNT_W   = 3;
	localparam int CC_W    = 3;
	localparam int CHILD_W = 2;

	// defaults for the top level parameters
	localparam int DEF_MAX_CHILDREN = 4;
	localparam int DEF_TAG_COUNT    = 64;

	localparam logic [CC_W-1:0] CC_RESET = 3'd2;

	// request types
	localparam logic REQ_SUBMIT = 1'b0;
	localparam logic REQ_CPL    = 1'b1;

	// io kinds
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WZERO = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UNMAP = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RESET = 3'd5;

	// result kinds
	localparam logic RES_CMD = 1'b0;
	localparam logic RES_CPL = 1'b1;

	// parent status
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

endpackage
`default_nettype wire

// File: rtl/core/raid1_mirror_dispatcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake              payload
// in        in_valid / in_ready    req_type io_kind tag in_offset in_blocks
//                                  accept_mask success
// out       out_valid / out_ready  result_kind child_index cmd_kind out_tag
//                                  out_offset out_blocks status last
// cfg       cfg_valid / cfg_ready  cfg_data (child_count)
//
// a submit gives one command word per child (up to 4 for a four-way mirrored write)
// or else a parent completion; a completion answers only when it ends the parent.
// completions do a read-modify-write of the per-tag count memory (one read
// port, one write port, read data registered) before the next word is taken.
// after reset a clearing pass writes zero to all TAG_COUNT count entries, one a
// cycle; in_ready stays low until the pass is done. cfg is always ready.
// the output register lets the next input word be taken while a result waits.
module raid1_mirror_dispatcher_core #(
	parameter int MAX_CHILDREN = r1md_pkg::DEF_MAX_CHILDREN,
	parameter int TAG_COUNT    = r1md_pkg::DEF_TAG_COUNT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [r1md_pkg::CC_W-1:0]      cfg_data,
	// input word
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           req_type,
	input  wire logic [r1md_pkg::KIND_W-1:0]    io_kind,
	input  wire logic [r1md_pkg::TAG_W-1:0]     tag,
	input  wire logic [r1md_pkg::OFF_W-1:0]     in_offset,
	input  wire logic [r1md_pkg::BLK_W-1:0]     in_blocks,
	input  wire logic [r1md_pkg::ACC_W-1:0]     accept_mask,
	input  wire logic                           success,
	// result word
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                result_kind,
	output logic      [r1md_pkg::CHILD_W-1:0]   child_index,
	output logic      [r1md_pkg::KIND_W-1:0]    cmd_kind,
	output logic      [r1md_pkg::TAG_W-1:0]     out_tag,
	output logic      [r1md_pkg::OFF_W-1:0]     out_offset,
	output logic      [r1md_pkg::BLK_W-1:0]     out_blocks,
	output logic                                status,
	output logic                                last
);

	localparam int SLOT_W   = $clog2(TAG_COUNT);
	localparam int TAG_VALS = 2 ** r1md_pkg::TAG_W;

	logic [r1md_pkg::CC_W-1:0]  cc_q;
	logic [r1md_pkg::CC_W-1:0]  n_act;
	logic                       clr_busy_q;
	logic [SLOT_W-1:0]          clr_addr_q;
	logic [SLOT_W-1:0]          slot_lut [TAG_VALS];
	logic [SLOT_W-1:0]          slot;

	logic                       eng_rd_en;
	logic [SLOT_W-1:0]          eng_rd_addr;
	logic                       eng_wr_en;
	logic [SLOT_W-1:0]          eng_wr_addr;
	logic [r1md_pkg::CNT_W-1:0] eng_wr_data;
	logic [r1md_pkg::CNT_W-1:0] mem_rd_data;
	logic                       mem_wr_en;
	logic [SLOT_W-1:0]          mem_wr_addr;
	logic [r1md_pkg::CNT_W-1:0] mem_wr_data;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= r1md_pkg::CC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cc_q <= cfg_data;
		end
	end

	// zero means one child, anything above the build limit is clamped
	always_comb begin
		if (cc_q == '0) begin
			n_act = 3'd1;
		end else if (4'(cc_q) > 4'(MAX_CHILDREN)) begin
			n_act = 3'(MAX_CHILDREN);
		end else begin
			n_act = cc_q;
		end
	end

	// tag to count slot, fixed table
	for (genvar g = 0; g < TAG_VALS; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % TAG_COUNT);
	end
	assign slot = slot_lut[tag];

	// clearing pass over the count memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + SLOT_W'(1);
			if (clr_addr_q == SLOT_W'(TAG_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_wr_en   = clr_busy_q || eng_wr_en;
	assign mem_wr_addr = clr_busy_q ? clr_addr_q : eng_wr_addr;
	assign mem_wr_data = clr_busy_q ? '0 : eng_wr_data;

	r1md_cnt_mem #(
		.DEPTH  (TAG_COUNT),
		.ADDR_W (SLOT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (eng_rd_en),
		.rd_addr (eng_rd_addr),
		.rd_data (mem_rd_data)
	);

	r1md_engine #(
		.MAX_CHILDREN (MAX_CHILDREN),
		.SLOT_W       (SLOT_W)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable        (!clr_busy_q),
		.n_act         (n_act),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.io_kind       (io_kind),
		.tag           (tag),
		.slot          (slot),
		.in_offset     (in_offset),
		.in_blocks     (in_blocks),
		.accept_mask   (accept_mask),
		.success       (success),
		.rd_en         (eng_rd_en),
		.rd_addr       (eng_rd_addr),
		.rd_data       (mem_rd_data),
		.wr_en         (eng_wr_en),
		.wr_addr       (eng_wr_addr),
		.wr_data       (eng_wr_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.child_index   (child_index),
		.cmd_kind      (cmd_kind),
		.out_tag       (out_tag),
		.out_offset    (out_offset),
		.out_blocks    (out_blocks),
		.status        (status),
		.last          (last)
	);

	// no word is taken while the clearing pass owns the memory
	a_clr_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("input taken during count clear");

	a_clr_no_eng_wr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !eng_wr_en)
		else $error("engine write during count clear");

	// a submit always yields a result, so the engine is busy right after
	a_submit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (req_type == r1md_pkg::REQ_SUBMIT)) |=> !in_ready)
		else $error("submit finished without a result");

	// memory read and write never overlap for the engine
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		eng_rd_en |-> !eng_wr_en)
		else $error("count read and write in one cycle");

endmodule
`default_nettype wire

// File: rtl/core/r1md_cnt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module r1md_cnt_mem #(
	parameter int DEPTH  = r1md_pkg::DEF_TAG_COUNT,
	parameter int ADDR_W = $clog2(r1md_pkg::DEF_TAG_COUNT)
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [ADDR_W-1:0]            wr_addr,
	input  wire logic [r1md_pkg::CNT_W-1:0]   wr_data,
	input  wire logic                         rd_en,
	input  wire logic [ADDR_W-1:0]            rd_addr,
	output logic      [r1md_pkg::CNT_W-1:0]   rd_data
);

	logic [r1md_pkg::CNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/r1md_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module r1md_engine #(
	parameter int MAX_CHILDREN = r1md_pkg::DEF_MAX_CHILDREN,
	parameter int SLOT_W       = $clog2(r1md_pkg::DEF_TAG_COUNT)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           enable,
	input  wire logic [r1md_pkg::CC_W-1:0]      n_act,
	// input word
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           req_type,
	input  wire logic [r1md_pkg::KIND_W-1:0]    io_kind,
	input  wire logic [r1md_pkg::TAG_W-1:0]     tag,
	input  wire logic [SLOT_W-1:0]              slot,
	input  wire logic [r1md_pkg::OFF_W-1:0]     in_offset,
	input  wire logic [r1md_pkg::BLK_W-1:0]     in_blocks,
	input  wire logic [r1md_pkg::ACC_W-1:0]     accept_mask,
	input  wire logic                           success,
	// count memory
	output logic                                rd_en,
	output logic      [SLOT_W-1:0]              rd_addr,
	input  wire logic [r1md_pkg::CNT_W-1:0]     rd_data,
	output logic                                wr_en,
	output logic      [SLOT_W-1:0]              wr_addr,
	output logic      [r1md_pkg::CNT_W-1:0]     wr_data,
	// result word
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                result_kind,
	output logic      [r1md_pkg::CHILD_W-1:0]   child_index,
	output logic      [r1md_pkg::KIND_W-1:0]    cmd_kind,
	output logic      [r1md_pkg::TAG_W-1:0]     out_tag,
	output logic      [r1md_pkg::OFF_W-1:0]     out_offset,
	output logic      [r1md_pkg::BLK_W-1:0]     out_blocks,
	output logic                                status,
	output logic                                last
);

	localparam int RP_W = $clog2(MAX_CHILDREN);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_CMD  = 4'b0100,
		S_CPL  = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [RP_W-1:0]               rp_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [r1md_pkg::TAG_W-1:0]    tag_q;
	logic [r1md_pkg::KIND_W-1:0]   kind_q;
	logic [r1md_pkg::OFF_W-1:0]    off_q;
	logic [r1md_pkg::BLK_W-1:0]    blk_q;
	logic [r1md_pkg::ACC_W-1:0]    mask_q;
	logic                          status_q;

	logic                          out_valid_q;
	logic                          res_kind_q;
	logic [r1md_pkg::CHILD_W-1:0]  child_q;
	logic [r1md_pkg::KIND_W-1:0]   cmd_q;
	logic [r1md_pkg::TAG_W-1:0]    otag_q;
	logic [r1md_pkg::OFF_W-1:0]    ooff_q;
	logic [r1md_pkg::BLK_W-1:0]    oblk_q;
	logic                          ostat_q;
	logic                          olast_q;

	logic                          fire;
	logic                          out_free;
	logic [2:0]                    rp3;
	logic [2:0]                    idx3;
	logic [2:0]                    rp_next;
	logic                          read_ok;
	logic [r1md_pkg::ACC_W-1:0]    act_mask;
	logic [r1md_pkg::ACC_W-1:0]    eff_mask;
	logic [r1md_pkg::ACC_W-1:0]    sub_mask;
	logic [r1md_pkg::CNT_W-1:0]    sub_cnt;
	logic                          is_reset;
	logic [r1md_pkg::CHILD_W-1:0]  low_child;
	logic                          mask_single;

	assign in_ready = enable && (state_q == S_IDLE);
	assign fire     = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// read pointer: a stale pointer past the child count falls back to child 0
	assign rp3     = 3'(rp_q);
	assign idx3    = (rp3 >= n_act) ? 3'd0 : rp3;
	assign rp_next = ((idx3 + 3'd1) == n_act) ? 3'd0 : (idx3 + 3'd1);
	assign read_ok = (idx3 < 3'd4) && accept_mask[idx3[1:0]];

	always_comb begin
		for (int i = 0; i < r1md_pkg::ACC_W; i++) begin
			act_mask[i] = (3'(i) < n_act);
		end
	end

	assign eff_mask = accept_mask & act_mask;
	assign is_reset = (io_kind == r1md_pkg::KIND_RESET);

	always_comb begin
		unique case (io_kind) inside
			r1md_pkg::KIND_READ: begin
				sub_mask = read_ok ? (4'b0001 << idx3[1:0]) : '0;
				sub_cnt  = read_ok ? 3'd1 : 3'd0;
			end
			r1md_pkg::KIND_WRITE, r1md_pkg::KIND_WZERO, r1md_pkg::KIND_UNMAP,
			r1md_pkg::KIND_FLUSH, r1md_pkg::KIND_RESET: begin
				sub_mask = eff_mask;
				sub_cnt  = 3'(eff_mask[0]) + 3'(eff_mask[1])
					+ 3'(eff_mask[2]) + 3'(eff_mask[3]);
			end
			default: begin
				sub_mask = '0;
				sub_cnt  = '0;
			end
		endcase
	end

	// lowest pending child goes out first
	always_comb begin
		if (mask_q[0]) begin
			low_child = 2'd0;
		end else if (mask_q[1]) begin
			low_child = 2'd1;
		end else if (mask_q[2]) begin
			low_child = 2'd2;
		end else begin
			low_child = 2'd3;
		end
	end

	assign mask_single = ((mask_q & (mask_q - 4'd1)) == '0);

	// completions read the count at accept and write it back in S_READ;
	// the next word is taken only after that write lands
	assign rd_en   = fire && (req_type == r1md_pkg::REQ_CPL);
	assign rd_addr = slot;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot;
		wr_data = sub_cnt;
		if (state_q == S_READ) begin
			wr_en   = (rd_data != '0);
			wr_addr = slot_q;
			wr_data = rd_data - 3'd1;
		end else if (fire && (req_type == r1md_pkg::REQ_SUBMIT)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						if (req_type == r1md_pkg::REQ_CPL) begin
							state_q <= S_READ;
						end else if (sub_mask != '0) begin
							state_q <= S_CMD;
						end else begin
							state_q <= S_CPL;
						end
						if ((req_type == r1md_pkg::REQ_SUBMIT)
							&& (io_kind == r1md_pkg::KIND_READ)) begin
							rp_q <= RP_W'(rp_next);
						end
					end
				end
				S_READ: begin
					state_q <= (rd_data == 3'd1) ? S_CPL : S_IDLE;
				end
				S_CMD: begin
					if (out_free && mask_single) begin
						state_q <= S_IDLE;
					end
				end
				S_CPL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			slot_q   <= slot;
			tag_q    <= tag;
			kind_q   <= io_kind;
			off_q    <= is_reset ? '0 : in_offset;
			blk_q    <= is_reset ? '0 : in_blocks;
			mask_q   <= sub_mask;
			status_q <= (req_type == r1md_pkg::REQ_CPL) ? !success : r1md_pkg::ST_FAIL;
		end else if ((state_q == S_CMD) && out_free) begin
			mask_q <= mask_q & (mask_q - 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == S_CMD) || (state_q == S_CPL)) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_CMD) && out_free) begin
			res_kind_q <= r1md_pkg::RES_CMD;
			child_q    <= low_child;
			cmd_q      <= kind_q;
			otag_q     <= tag_q;
			ooff_q     <= off_q;
			oblk_q     <= blk_q;
			ostat_q    <= r1md_pkg::ST_OK;
			olast_q    <= mask_single;
		end else if ((state_q == S_CPL) && out_free) begin
			res_kind_q <= r1md_pkg::RES_CPL;
			child_q    <= '0;
			cmd_q      <= '0;
			otag_q     <= tag_q;
			ooff_q     <= '0;
			oblk_q     <= '0;
			ostat_q    <= status_q;
			olast_q    <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = res_kind_q;
	assign child_index = child_q;
	assign cmd_kind    = cmd_q;
	assign out_tag     = otag_q;
	assign out_offset  = ooff_q;
	assign out_blocks  = oblk_q;
	assign status      = ostat_q;
	assign last        = olast_q;

endmodule
`default_nettype wire

// File: test/raid1_mirror_dispatcher_core_tb.sv
`timescale 1ns / 1ps
module raid1_mirror_dispatcher_core_tb;

	localparam int MAX_KIDS = r1md_pkg::DEF_MAX_CHILDREN;
	localparam int TAGS = r1md_pkg::DEF_TAG_COUNT;
	localparam int CC_W = r1md_pkg::CC_W;
	localparam int KIND_W = r1md_pkg::KIND_W;
	localparam int TAG_W = r1md_pkg::TAG_W;
	localparam int OFF_W = r1md_pkg::OFF_W;
	localparam int BLK_W = r1md_pkg::BLK_W;
	localparam int ACC_W = r1md_pkg::ACC_W;
	localparam int CNT_W = r1md_pkg::CNT_W;
	localparam int CHILD_W = r1md_pkg::CHILD_W;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

	typedef struct {
		logic              req;
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  tag;
		logic [OFF_W-1:0]  off;
		logic [BLK_W-1:0]  blk;
		logic [ACC_W-1:0]  acc;
		logic              ok;
	} parent_req_t;

	typedef struct {
		logic               kind;
		logic [CHILD_W-1:0] child;
		logic [KIND_W-1:0]  cmd;
		logic [TAG_W-1:0]   tag;
		logic [OFF_W-1:0]   off;
		logic [BLK_W-1:0]   blk;
		logic               st;
		logic               last;
	} dispatch_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CC_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [KIND_W-1:0] io_kind = '0;
	logic [TAG_W-1:0] tag = '0;
	logic [OFF_W-1:0] in_offset = '0;
	logic [BLK_W-1:0] in_blocks = '0;
	logic [ACC_W-1:0] accept_mask = '0;
	logic success = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic [CHILD_W-1:0] child_index;
	logic [KIND_W-1:0] cmd_kind;
	logic [TAG_W-1:0] out_tag;
	logic [OFF_W-1:0] out_offset;
	logic [BLK_W-1:0] out_blocks;
	logic status;
	logic last;

	// mirror state as the block should hold it
	logic [CC_W-1:0] mirror_cfg = r1md_pkg::CC_RESET;
	int unsigned rr_ptr = 0;
	logic [CNT_W-1:0] tag_pending [TAGS];

	parent_req_t host_req_q[$];
	dispatch_word_t dispatch_words_q[$];
	parent_req_t cur_req;
	dispatch_word_t head_word;
	int unsigned reqs_queued = 0;
	int unsigned reqs_taken = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_cycles = 0;
	logic [7:0] ready_pat = 8'hff;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned align_reads;

	raid1_mirror_dispatcher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.io_kind(io_kind),
		.tag(tag),
		.in_offset(in_offset),
		.in_blocks(in_blocks),
		.accept_mask(accept_mask),
		.success(success),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.child_index(child_index),
		.cmd_kind(cmd_kind),
		.out_tag(out_tag),
		.out_offset(out_offset),
		.out_blocks(out_blocks),
		.status(status),
		.last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned active_kids(input logic [CC_W-1:0] cc);
		if (cc == 0)
			return 1;
		if (cc > MAX_KIDS)
			return MAX_KIDS;
		return cc;
	endfunction

	function automatic void push_word(input logic kind, input logic [CHILD_W-1:0] child,
			input logic [KIND_W-1:0] cmd, input logic [TAG_W-1:0] t,
			input logic [OFF_W-1:0] off, input logic [BLK_W-1:0] blk,
			input logic st, input logic lst);
		dispatch_word_t w;
		w.kind = kind;
		w.child = child;
		w.cmd = cmd;
		w.tag = t;
		w.off = off;
		w.blk = blk;
		w.st = st;
		w.last = lst;
		dispatch_words_q.push_back(w);
	endfunction

	// expected child commands or parent completion for one accepted word
	function automatic void mirror_dispatch(input parent_req_t r);
		int unsigned nact;
		int unsigned idx;
		int unsigned hits;
		logic [OFF_W-1:0] fwd_off;
		logic [BLK_W-1:0] fwd_blk;
		nact = active_kids(mirror_cfg);
		hits = 0;
		if (r.req == r1md_pkg::REQ_CPL) begin
			if (tag_pending[r.tag] == 0)
				return;
			tag_pending[r.tag] = tag_pending[r.tag] - CNT_W'(1);
			if (tag_pending[r.tag] == 0)
				push_word(r1md_pkg::RES_CPL, '0, '0, r.tag, '0, '0,
					r.ok ? r1md_pkg::ST_OK : r1md_pkg::ST_FAIL, 1'b1);
		end else if (r.kind == r1md_pkg::KIND_READ) begin
			// pointer left past a lowered count falls back to child 0
			idx = (rr_ptr >= nact) ? 0 : rr_ptr;
			rr_ptr = (idx + 1) % nact;
			if (r.acc[idx]) begin
				tag_pending[r.tag] = CNT_W'(1);
				push_word(r1md_pkg::RES_CMD, CHILD_W'(idx), r1md_pkg::KIND_READ, r.tag,
					r.off, r.blk, r1md_pkg::ST_OK, 1'b1);
			end else begin
				tag_pending[r.tag] = '0;
				push_word(r1md_pkg::RES_CPL, '0, '0, r.tag, '0, '0, r1md_pkg::ST_FAIL, 1'b1);
			end
		end else if (r.kind <= r1md_pkg::KIND_RESET) begin
			fwd_off = (r.kind == r1md_pkg::KIND_RESET) ? '0 : r.off;
			fwd_blk = (r.kind == r1md_pkg::KIND_RESET) ? '0 : r.blk;
			for (idx = 0; idx < nact; idx++) begin
				if (r.acc[idx]) begin
					push_word(r1md_pkg::RES_CMD, CHILD_W'(idx), r.kind, r.tag, fwd_off,
						fwd_blk, r1md_pkg::ST_OK, 1'b0);
					hits++;
				end
			end
			tag_pending[r.tag] = CNT_W'(hits);
			if (hits != 0)
				dispatch_words_q[dispatch_words_q.size() - 1].last = 1'b1;
			else
				push_word(r1md_pkg::RES_CPL, '0, '0, r.tag, '0, '0, r1md_pkg::ST_FAIL, 1'b1);
		end else begin
			tag_pending[r.tag] = '0;
			push_word(r1md_pkg::RES_CPL, '0, '0, r.tag, '0, '0, r1md_pkg::ST_FAIL, 1'b1);
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [OFF_W-1:0] rand_off();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return w[OFF_W-1:0];
		endcase
	endfunction

	function automatic logic [BLK_W-1:0] rand_blk();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 256);
			default: return $urandom;
		endcase
	endfunction

	function automatic void push_req(input logic req, input logic [KIND_W-1:0] kind,
			input logic [TAG_W-1:0] t, input logic [OFF_W-1:0] off,
			input logic [BLK_W-1:0] blk, input logic [ACC_W-1:0] acc, input logic ok);
		parent_req_t r;
		r.req = req;
		r.kind = kind;
		r.tag = t;
		r.off = off;
		r.blk = blk;
		r.acc = acc;
		r.ok = ok;
		host_req_q.push_back(r);
		reqs_queued++;
	endfunction

	// submits followed by completions on open tags, with some stray words mixed in
	function automatic void gen_traffic(input int unsigned count, input int unsigned nact);
		logic [TAG_W-1:0] open_tag[$];
		int unsigned open_left[$];
		logic [ACC_W-1:0] live_mask;
		logic [KIND_W-1:0] kind;
		logic [ACC_W-1:0] acc;
		logic [TAG_W-1:0] t;
		int unsigned pick;
		int unsigned i;
		int unsigned j;
		int unsigned est;
		live_mask = ACC_W'((1 << nact) - 1);
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 || open_tag.size() == 0) begin
				t = ($urandom_range(0, 7) == 0) ? TAG_W'($urandom_range(0, TAGS - 1)) :
					TAG_W'($urandom_range(0, 15));
				pick = $urandom_range(0, 9);
				if (pick < 3)
					kind = r1md_pkg::KIND_READ;
				else if (pick < 9)
					kind = KIND_W'($urandom_range(r1md_pkg::KIND_WRITE, r1md_pkg::KIND_RESET));
				else
					kind = KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
				acc = ($urandom_range(0, 2) == 0) ? 4'hf : ACC_W'($urandom_range(0, 15));
				if (kind == r1md_pkg::KIND_READ)
					est = 1;
				else if (kind <= r1md_pkg::KIND_RESET)
					est = $countones(acc & live_mask);
				else
					est = 0;
				if (est != 0) begin
					open_tag.push_back(t);
					open_left.push_back(est);
				end
				push_req(r1md_pkg::REQ_SUBMIT, kind, t, rand_off(), rand_blk(), acc,
					1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				j = $urandom_range(0, open_tag.size() - 1);
				push_req(r1md_pkg::REQ_CPL, KIND_W'($urandom_range(0, 7)), open_tag[j],
					rand_off(), rand_blk(), ACC_W'($urandom_range(0, 15)),
					$urandom_range(0, 4) != 0);
				open_left[j]--;
				if (open_left[j] == 0) begin
					open_tag.delete(j);
					open_left.delete(j);
				end
			end else begin
				push_req(r1md_pkg::REQ_CPL, KIND_W'($urandom_range(0, 7)),
					TAG_W'($urandom_range(0, TAGS - 1)), rand_off(), rand_blk(),
					ACC_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			end
		end
	endfunction

	task automatic wait_drained();
		do
			@(posedge clk);
		while (reqs_taken != reqs_queued || dispatch_words_q.size() != 0);
		// a completion that finishes nothing may still be in the count pipeline
		repeat (8) @(posedge clk);
	endtask

	task automatic write_child_count(input logic [CC_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror_cfg = v;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				mirror_dispatch(cur_req);
				reqs_taken++;
			end
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (host_req_q.size() != 0) begin
					cur_req = host_req_q.pop_front();
					req_type <= cur_req.req;
					io_kind <= cur_req.kind;
					tag <= cur_req.tag;
					in_offset <= cur_req.off;
					in_blocks <= cur_req.blk;
					accept_mask <= cur_req.acc;
					success <= cur_req.ok;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_cycles == 0) begin
				stall_mode = $urandom_range(0, 3);
				ready_pat = 8'($urandom) | 8'h01;
				stall_cycles = $urandom_range(20, 120);
			end else begin
				stall_cycles--;
			end
			ready_pat = {ready_pat[6:0], ready_pat[7]};
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ready_pat[0];
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (dispatch_words_q.size() == 0) begin
				$error("result word with nothing expected: tag %0h kind %0b", out_tag,
					result_kind);
				mismatches++;
			end else begin
				head_word = dispatch_words_q.pop_front();
				check_field("result_kind", head_word.kind, result_kind);
				check_field("child_index", head_word.child, child_index);
				check_field("cmd_kind", head_word.cmd, cmd_kind);
				check_field("out_tag", head_word.tag, out_tag);
				check_field("out_offset", head_word.off, out_offset);
				check_field("out_blocks", head_word.blk, out_blocks);
				check_field("status", head_word.st, status);
				check_field("last", head_word.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("raid1_mirror_dispatcher_core verification failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < TAGS; i++)
			tag_pending[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed, two children as after reset
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_READ, 6'd0, '1, '1, 4'hf, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd0, '0, '0, 4'h0, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_READ, 6'd1, 48'h1234, 32'd8, 4'h0,
			1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_WRITE, 6'd2, '0, '0, 4'hf, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_WRITE, 6'd2, '0, '0, 4'h0, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_WRITE, 6'd2, '0, '0, 4'h0, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_WRITE, 6'd2, '1, '1, 4'hf, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_WZERO, 6'd3, 48'h800000000000,
			32'h80000000, 4'h2, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_UNMAP, 6'd4, 48'h0000ffff0000,
			32'h0000ffff, 4'h1, 1'b0);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_FLUSH, 6'd5, 48'h7, 32'h7, 4'h3, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_RESET, 6'd6, '1, '1, 4'h3, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, KIND_BAD_LO, 6'd7, '1, '1, 4'hf, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, KIND_BAD_HI, 6'd63, '1, '1, 4'hf, 1'b1);
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_WRITE, 6'd8, 48'h10, 32'h10, 4'h0, 1'b1);
		// busy tag gets overwritten
		push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_WRITE, 6'd3, 48'h20, 32'h1, 4'hf, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd3, '0, '0, 4'h0, 1'b1);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd3, '0, '0, 4'h0, 1'b1);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd4, '0, '0, 4'h0, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd5, '0, '0, 4'h0, 1'b1);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd5, '0, '0, 4'h0, 1'b1);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd6, '0, '0, 4'h0, 1'b1);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd6, '0, '0, 4'h0, 1'b0);
		push_req(r1md_pkg::REQ_CPL, r1md_pkg::KIND_READ, 6'd63, '0, '0, 4'h0, 1'b1);
		wait_drained();

		write_child_count(3'd4);
		gen_traffic(40, active_kids(3'd4));
		wait_drained();
		// leave the read pointer on child 3 so the lower count has to wrap it
		align_reads = (3 - rr_ptr) & 3;
		repeat (align_reads)
			push_req(r1md_pkg::REQ_SUBMIT, r1md_pkg::KIND_READ,
				TAG_W'($urandom_range(0, TAGS - 1)), rand_off(), rand_blk(),
				ACC_W'($urandom_range(0, 15)), 1'b1);
		wait_drained();

		write_child_count(3'd3);
		gen_traffic(40, active_kids(3'd3));
		wait_drained();
		write_child_count(3'd1);
		gen_traffic(40, active_kids(3'd1));
		wait_drained();
		write_child_count(3'd0);
		gen_traffic(40, active_kids(3'd0));
		wait_drained();
		write_child_count(3'd7);
		gen_traffic(40, active_kids(3'd7));
		wait_drained();
		write_child_count(3'd2);
		gen_traffic(40, active_kids(3'd2));
		wait_drained();
		write_child_count(3'd5);
		gen_traffic(40, active_kids(3'd5));
		wait_drained();
		write_child_count(3'd4);
		gen_traffic(40, active_kids(3'd4));
		wait_drained();
		write_child_count(3'd6);
		gen_traffic(40, active_kids(3'd6));
		wait_drained();

		if (mismatches == 0)
			$display("raid1_mirror_dispatcher_core verification clean");
		else
			$display("raid1_mirror_dispatcher_core verification failed");
		$finish;
	end

endmodule
